// File: hdl/olvd_pkg.sv
// Shared types and constants for the ordered value list.
package olvd_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 8;

	typedef enum logic [1:0] {
		CMD_APPEND    = 2'd0,
		CMD_REM_HEAD  = 2'd1,
		CMD_REM_TAIL  = 2'd2,
		CMD_REM_VALUE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic             shift_all;
		logic             search;
		logic [VAL_W-1:0] value;
	} cell_ctrl_t;

endpackage

// File: hdl/olvd_cell.sv
// One list cell: holds an entry, compares it, and shifts from its neighbor.
module olvd_cell
	import olvd_pkg::*;
(
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic             load,
	input  logic             occ,
	input  logic             hit_in,
	input  logic [VAL_W-1:0] nxt_data,
	output logic             hit_out,
	output logic [VAL_W-1:0] data
);

	logic [VAL_W-1:0] data_q;
	logic             match;

	assign match   = ctrl.search & occ & (data_q == ctrl.value);
	assign hit_out = hit_in | match;
	assign data    = data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= ctrl.value;
		end else if (ctrl.shift_all | (ctrl.search & hit_out)) begin
			data_q <= nxt_data;
		end
	end

endmodule

// File: hdl/ordered_list_with_value_delete.sv
// Top level: bounded ordered list of values with delete by value.
//
//  channel  | dir | handshake        | payload
//  s_axis   | in  | tvalid / tready  | tdata[1:0] command, [33:2] value, [39:34] zero
//  m_axis   | out | tvalid / tready  | tdata[1:0] status, [6:2] entry_count, [7] zero
//
// One command per cycle; the result appears in the output register in the cycle
// after the input word is accepted. The row of cells compares and shifts in
// parallel, so the update is registered with the result. Reset clears the count and
// the output valid; entries need no reset. A stalled result holds the input
// side until it is taken, with a new word accepted in the same cycle it leaves.
module ordered_list_with_value_delete
	import olvd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,   // command[1:0], value[33:2]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata    // status[1:0], entry_count[6:2]
);

	logic [CNT_W-1:0] count_q;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic             accept;
	cmd_t             cmd;
	logic [VAL_W-1:0] value;
	logic             empty;
	logic             full;
	cell_ctrl_t       ctrl;
	logic [CAPACITY:0]         hit;
	logic [VAL_W-1:0]          data [CAPACITY];
	logic [CAPACITY-1:0]       load;
	logic [CAPACITY-1:0]       occ;
	status_t          status;
	logic [CNT_W-1:0] count_d;

	assign s_axis_tready = ~m_tvalid_q | m_axis_tready;
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign cmd           = cmd_t'(s_axis_tdata[1:0]);
	assign value         = s_axis_tdata[VAL_W+1:2];
	assign empty         = (count_q == '0);
	assign full          = (count_q == CNT_W'(CAPACITY));

	assign ctrl.shift_all = accept & (cmd == CMD_REM_HEAD) & ~empty;
	assign ctrl.search    = accept & (cmd == CMD_REM_VALUE);
	assign ctrl.value     = value;
	assign hit[0]         = 1'b0;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [VAL_W-1:0] nxt;
			if (gi == CAPACITY - 1) begin : g_last
				assign nxt = data[gi];
			end else begin : g_mid
				assign nxt = data[gi+1];
			end
			assign occ[gi]  = (CNT_W'(gi) < count_q);
			assign load[gi] = accept & (cmd == CMD_APPEND) & (count_q == CNT_W'(gi));
			olvd_cell u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.load     (load[gi]),
				.occ      (occ[gi]),
				.hit_in   (hit[gi]),
				.nxt_data (nxt),
				.hit_out  (hit[gi+1]),
				.data     (data[gi])
			);
		end
	endgenerate

	always_comb begin
		status  = ST_OK;
		count_d = count_q;
		case (cmd)
			CMD_APPEND: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_REM_HEAD, CMD_REM_TAIL: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			CMD_REM_VALUE: begin
				if (hit[CAPACITY]) begin
					count_d = count_q - CNT_W'(1);
				end else begin
					status = ST_NOT_FOUND;
				end
			end
			default: begin
				status  = ST_OK;
				count_d = count_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_d;
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {1'b0, 5'(count_d), status};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the ordered value list with delete by value.
`timescale 1ns / 1ps

module tb;
	import olvd_pkg::*;

	localparam int  RESET_CYCLES = 12;
	localparam int  CYCLE_LIMIT  = 200000;
	localparam int  RANDOM_ITEMS = 1100;
	localparam int  QUIET_TAIL   = 150;
	localparam int  HOLD_OFF     = 80;
	localparam int  HOLD_AFTER   = 200;

	typedef struct {
		cmd_t        op;
		logic [31:0] value;
	} list_cmd_t;

	typedef struct {
		status_t    status;
		logic [4:0] count;
	} list_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;   // command[1:0], value[33:2], zero[39:34]
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;        // status[1:0], entry_count[6:2], zero[7]

	list_cmd_t    cmd_backlog [$];
	list_result_t due_results [$];
	logic [31:0]  list_model [$];
	logic [31:0]  value_pool [8];

	int  mismatches = 0;
	int  results_seen = 0;
	int  cycles = 0;
	int  src_gap = 0;
	int  sink_gap = 0;
	int  hold_left = 0;
	bit  held_once = 1'b0;
	bit  quiet = 1'b0;

	ordered_list_with_value_delete dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic list_result_t predict_step(input list_cmd_t c);
		list_result_t r;
		int           idx;
		r.status = ST_OK;
		case (c.op)
			CMD_APPEND: begin
				if (list_model.size() >= CAPACITY)
					r.status = ST_FULL;
				else
					list_model.push_back(c.value);
			end
			CMD_REM_HEAD: begin
				if (list_model.size() == 0)
					r.status = ST_EMPTY;
				else
					void'(list_model.pop_front());
			end
			CMD_REM_TAIL: begin
				if (list_model.size() == 0)
					r.status = ST_EMPTY;
				else
					void'(list_model.pop_back());
			end
			default: begin
				r.status = ST_NOT_FOUND;
				for (idx = 0; idx < list_model.size(); idx++) begin
					if (list_model[idx] == c.value) begin
						list_model.delete(idx);
						r.status = ST_OK;
						break;
					end
				end
			end
		endcase
		r.count = 5'(list_model.size());
		return r;
	endfunction

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 99) < 85)
			return value_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	task automatic queue_cmd(input cmd_t op, input logic [31:0] value);
		list_cmd_t c;
		c.op    = op;
		c.value = value;
		cmd_backlog.push_back(c);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			src_gap       <= 0;
			quiet         <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				due_results.push_back(predict_step(cmd_backlog[0]));
				void'(cmd_backlog.pop_front());
			end
			quiet <= (cmd_backlog.size() < QUIET_TAIL);
			if (s_axis_tvalid && !s_axis_tready) begin
				// hold the word until taken
			end else if (src_gap > 0) begin
				src_gap       <= src_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (cmd_backlog.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
				src_gap       <= $urandom_range(0, 8);
				s_axis_tvalid <= 1'b0;
			end else if (cmd_backlog.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {6'b0, cmd_backlog[0].value, cmd_backlog[0].op};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result-side flow control
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_gap      <= 0;
			hold_left     <= 0;
			held_once     <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!held_once && results_seen >= HOLD_AFTER) begin
			held_once     <= 1'b1;
			hold_left     <= HOLD_OFF;
			m_axis_tready <= 1'b0;
		end else if (sink_gap > 0) begin
			sink_gap      <= sink_gap - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			sink_gap      <= $urandom_range(0, 8);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen <= results_seen + 1;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d count %0d",
						m_axis_tdata[1:0], m_axis_tdata[6:2]);
			end else begin
				if (m_axis_tdata[1:0] !== due_results[0].status ||
				    m_axis_tdata[6:2] !== due_results[0].count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected status %0d count %0d, got status %0d count %0d",
							due_results[0].status, due_results[0].count,
							m_axis_tdata[1:0], m_axis_tdata[6:2]);
				end
				void'(due_results.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		int n;
		int seg;
		int mode;
		int r;
		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7FFF_FFFF;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hFFFF_FFFF;
		for (n = 4; n < 8; n++)
			value_pool[n] = $urandom;

		queue_cmd(CMD_REM_HEAD, 32'h0);
		queue_cmd(CMD_REM_TAIL, 32'hFFFF_FFFF);
		queue_cmd(CMD_REM_VALUE, 32'h0);
		queue_cmd(CMD_APPEND, 32'h8000_0000);
		queue_cmd(CMD_APPEND, 32'h7FFF_FFFF);
		queue_cmd(CMD_APPEND, 32'h0000_0000);
		queue_cmd(CMD_APPEND, 32'hFFFF_FFFF);
		queue_cmd(CMD_APPEND, 32'h7FFF_FFFF);
		queue_cmd(CMD_REM_VALUE, 32'h7FFF_FFFF);
		queue_cmd(CMD_REM_VALUE, 32'h0000_0005);
		queue_cmd(CMD_REM_VALUE, 32'h7FFF_FFFF);
		queue_cmd(CMD_REM_HEAD, 32'h0);
		queue_cmd(CMD_REM_TAIL, 32'h0);
		queue_cmd(CMD_REM_VALUE, 32'h0);
		queue_cmd(CMD_REM_VALUE, 32'hFFFF_FFFF);

		n = 0;
		while (n < RANDOM_ITEMS) begin
			// grow, shrink or mix, so the list sweeps between empty and full
			mode = $urandom_range(0, 2);
			seg  = $urandom_range(8, 40);
			repeat (seg) begin
				r = $urandom_range(0, 99);
				if ((mode == 0 && r < 80) || (mode == 1 && r < 20) || (mode == 2 && r < 45))
					queue_cmd(CMD_APPEND, pick_value());
				else begin
					case ($urandom_range(0, 3))
						0:       queue_cmd(CMD_REM_HEAD, $urandom);
						1:       queue_cmd(CMD_REM_TAIL, $urandom);
						default: queue_cmd(CMD_REM_VALUE, pick_value());
					endcase
				end
				n++;
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_backlog.size() != 0 || s_axis_tvalid || due_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (due_results.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
